// ----- src/kwl_pkg.sv -----
`timescale 1ns / 1ps

package kwl_pkg;

    // Width of the hold and pulse timers (8 to 32).
    localparam int TIMER_BITS = 16;

    typedef logic [TIMER_BITS-1:0] timer_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_KNOCK_THRESHOLDS = 3'd0;
    localparam logic [2:0] CFG_PULSE_PERIODS    = 3'd1;
    localparam logic [2:0] CFG_HOLD_TIME        = 3'd2;
    localparam logic [2:0] CFG_LOAD_FLOOR       = 3'd3;
    localparam logic [2:0] CFG_THROTTLE_FLOOR   = 3'd4;
    localparam logic [2:0] CFG_DROP_ON_IDLE     = 3'd5;

    // Bit positions of the hysteresis flags.
    localparam int FLAG_ONE   = 0;
    localparam int FLAG_TWO   = 1;
    localparam int FLAG_THREE = 2;

    // Warning level codes.
    localparam logic [1:0] LEVEL_NONE  = 2'd0;
    localparam logic [1:0] LEVEL_ONE   = 2'd1;
    localparam logic [1:0] LEVEL_TWO   = 2'd2;
    localparam logic [1:0] LEVEL_THREE = 2'd3;

    typedef struct packed {
        logic [47:0] knock_thresholds;
        logic [47:0] pulse_periods;
        logic [15:0] hold_time;
        logic [15:0] load_floor;
        logic [15:0] throttle_floor;
        logic        drop_on_idle;
    } cfg_t;

    typedef struct packed {
        logic [2:0] level_flags;
        logic [1:0] latched_level;
        timer_t     hold_timer;
        timer_t     pulse_timer;
    } state_t;

endpackage

// ----- src/kwl_if.sv -----
`timescale 1ns / 1ps

// Evaluation tick channel.
interface kwl_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] knock_level;
    logic [15:0] engine_load;
    logic [15:0] throttle;
    logic        not_running;
    logic        decay_tick;

    modport source (
        output valid, knock_level, engine_load, throttle, not_running, decay_tick,
        input  ready
    );
    modport sink (
        input  valid, knock_level, engine_load, throttle, not_running, decay_tick,
        output ready
    );
endinterface

// Lamp result channel.
interface kwl_out_if;
    logic       valid;
    logic       ready;
    logic       toggle_lamp;
    logic [1:0] warning_level;

    modport source (
        output valid, toggle_lamp, warning_level,
        input  ready
    );
    modport sink (
        input  valid, toggle_lamp, warning_level,
        output ready
    );
endinterface

// ----- src/kwl_eval.sv -----
`timescale 1ns / 1ps

module kwl_eval (
    input  kwl_pkg::cfg_t   cfg,
    input  kwl_pkg::state_t state,
    input  logic [15:0]     knock_level,
    input  logic [15:0]     engine_load,
    input  logic [15:0]     throttle,
    input  logic            not_running,
    input  logic            decay_tick,
    output kwl_pkg::state_t state_next,
    output logic            toggle_lamp
);
    import kwl_pkg::*;

    timer_t     hold_dec;
    timer_t     pulse_dec;
    state_t     base;
    logic [2:0] flags_new;
    logic       rising;
    logic       idle;
    logic [1:0] level_pick;
    logic [1:0] level_new;
    timer_t     hold_new;
    timer_t     pulse_new;
    timer_t     period;
    logic       toggle;

    // Decay both timers, saturating at zero.
    assign hold_dec  = (decay_tick && state.hold_timer != '0)
                       ? state.hold_timer - timer_t'(1) : state.hold_timer;
    assign pulse_dec = (decay_tick && state.pulse_timer != '0)
                       ? state.pulse_timer - timer_t'(1) : state.pulse_timer;

    // A stopped engine clears everything before evaluation.
    always_comb
    begin
        if (not_running)
        begin
            base = '0;
        end
        else
        begin
            base.level_flags   = state.level_flags;
            base.latched_level = state.latched_level;
            base.hold_timer    = hold_dec;
            base.pulse_timer   = pulse_dec;
        end
    end

    // Hysteresis per level: set above the high byte, clear below the low byte.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (knock_level > {8'd0, cfg.knock_thresholds[16*k+8 +: 8]})
                flags_new[k] = 1'b1;
            else if (knock_level < {8'd0, cfg.knock_thresholds[16*k +: 8]})
                flags_new[k] = 1'b0;
            else
                flags_new[k] = base.level_flags[k];
        end
    end

    // Rising is measured against the flags at the start of the tick.
    assign rising = |(flags_new & ~state.level_flags);
    assign idle   = (engine_load < cfg.load_floor) && (throttle < cfg.throttle_floor);

    // Highest flag that is set gives the level.
    always_comb
    begin
        if (flags_new[FLAG_THREE])
            level_pick = LEVEL_THREE;
        else if (flags_new[FLAG_TWO])
            level_pick = LEVEL_TWO;
        else if (flags_new[FLAG_ONE])
            level_pick = LEVEL_ONE;
        else
            level_pick = LEVEL_NONE;
    end

    // Level and hold timer update.
    always_comb
    begin
        level_new = base.latched_level;
        hold_new  = base.hold_timer;
        if (idle)
        begin
            if (cfg.drop_on_idle)
            begin
                hold_new  = '0;
                level_new = LEVEL_NONE;
            end
            else if (base.hold_timer == '0)
            begin
                level_new = LEVEL_NONE;
            end
        end
        else if (base.hold_timer == '0 || rising)
        begin
            level_new = level_pick;
            if (level_pick != LEVEL_NONE)
                hold_new = timer_t'(cfg.hold_time);
        end
    end

    // Flash period of the latched level, cut to the timer width.
    always_comb
    begin
        unique case (level_new)
            LEVEL_ONE:   period = timer_t'(cfg.pulse_periods[15:0]);
            LEVEL_TWO:   period = timer_t'(cfg.pulse_periods[31:16]);
            LEVEL_THREE: period = timer_t'(cfg.pulse_periods[47:32]);
            default:     period = '0;
        endcase
    end

    // Pulse timer reload and lamp toggle.
    always_comb
    begin
        pulse_new = '0;
        toggle    = 1'b0;
        if (level_new != LEVEL_NONE)
        begin
            pulse_new = (base.pulse_timer == '0 || rising) ? period : base.pulse_timer;
            toggle    = (pulse_new >= (period >> 1));
        end
    end

    assign state_next.level_flags   = flags_new;
    assign state_next.latched_level = level_new;
    assign state_next.hold_timer    = hold_new;
    assign state_next.pulse_timer   = pulse_new;
    assign toggle_lamp              = toggle;

endmodule

// ----- src/knock_warning_lamp_flasher.sv -----
`timescale 1ns / 1ps

// Knock warning lamp flasher.
// The tick channel carries one engine evaluation tick per word: knock sum,
// load, throttle, a not-running flag and a decay tick. The result channel
// returns one word per tick: a lamp toggle request and the latched level.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must do so only while no tick is in flight; the block does not enforce it.
// Indexes beyond the register list are ignored. Latency: a result is valid on
// the cycle after its tick is accepted. Throughput: one tick per cycle. The
// whole evaluation is one pass of compare and load logic from the state
// registers and the incoming word into the state and result registers, so
// the state feedback loop holds no other register.
// When the receiver stalls, the result register holds its word and the tick
// channel takes a new word only in the cycle the held word is taken.
// Reset clears the configuration, the flags, the level and both timers, and
// empties the result register.
module knock_warning_lamp_flasher (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [47:0]      cfg_wdata,
    kwl_in_if.sink           tick,
    kwl_out_if.source        result
);
    import kwl_pkg::*;

    cfg_t       cfg_reg;
    state_t     state_reg;
    state_t     state_next;
    logic       toggle_next;
    logic       out_valid_reg;
    logic       toggle_reg;
    logic [1:0] level_reg;
    logic       accept;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KNOCK_THRESHOLDS: cfg_reg.knock_thresholds <= cfg_wdata;
                CFG_PULSE_PERIODS:    cfg_reg.pulse_periods    <= cfg_wdata;
                CFG_HOLD_TIME:        cfg_reg.hold_time        <= cfg_wdata[15:0];
                CFG_LOAD_FLOOR:       cfg_reg.load_floor       <= cfg_wdata[15:0];
                CFG_THROTTLE_FLOOR:   cfg_reg.throttle_floor   <= cfg_wdata[15:0];
                CFG_DROP_ON_IDLE:     cfg_reg.drop_on_idle     <= cfg_wdata[0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // A word is taken when the result register is empty or being emptied.
    assign tick.ready = !out_valid_reg || result.ready;
    assign accept     = tick.valid && tick.ready;

    kwl_eval u_eval (
        .cfg         (cfg_reg),
        .state       (state_reg),
        .knock_level (tick.knock_level),
        .engine_load (tick.engine_load),
        .throttle    (tick.throttle),
        .not_running (tick.not_running),
        .decay_tick  (tick.decay_tick),
        .state_next  (state_next),
        .toggle_lamp (toggle_next)
    );

    // State registers advance once per accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            toggle_reg <= toggle_next;
            level_reg  <= state_next.latched_level;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.toggle_lamp   = toggle_reg;
    assign result.warning_level = level_reg;

    // The pulse timer is idle whenever no level is latched.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.latched_level == LEVEL_NONE |-> state_reg.pulse_timer == '0)
        else $error("pulse timer running with no latched level");

    // The word on offer reports the level now held in the state.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.warning_level == state_reg.latched_level)
        else $error("result level differs from latched level");

    // The lamp is only toggled while a level is latched.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.toggle_lamp |-> result.warning_level != LEVEL_NONE)
        else $error("lamp toggle with no warning level");

    // State moves only on an accepted word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(state_reg))
        else $error("state changed without an accepted word");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import kwl_pkg::*;

    // One evaluation tick as it goes into the block.
    typedef struct packed {
        logic [15:0] knock_level;
        logic [15:0] engine_load;
        logic [15:0] throttle;
        logic        not_running;
        logic        decay_tick;
    } tick_word_t;

    // One lamp word as it comes out of the block.
    typedef struct packed {
        logic       toggle_lamp;
        logic [1:0] warning_level;
    } lamp_word_t;

    // A row of the directed script; typed rows carry a hand-written result.
    typedef struct {
        int          section;
        logic [15:0] knock_level;
        logic [15:0] engine_load;
        logic [15:0] throttle;
        logic        not_running;
        logic        decay_tick;
        bit          typed;
        logic        toggle_lamp;
        logic [1:0]  warning_level;
    } script_row_t;

    localparam int PHASES          = 5;
    localparam int TICKS_PER_PHASE = 330;
    localparam int LONG_STALL_AT   = 150;
    localparam int LONG_STALL_LEN  = 80;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_wdata;

    kwl_in_if  tick_ch ();
    kwl_out_if lamp_ch ();

    knock_warning_lamp_flasher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tick      (tick_ch),
        .result    (lamp_ch)
    );

    // Shadow copy of the block's settings and state.
    cfg_t       lamp_cfg;
    logic [2:0] flags_m;
    logic [1:0] level_m;
    timer_t     hold_m;
    timer_t     pulse_m;

    lamp_word_t lamp_due_q[$];
    int         mismatch_count  = 0;
    int         lamp_words_seen = 0;
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         tx_burst_left;
    int         rx_burst_left   = 0;
    int         rx_hold_left    = 0;
    bit         rx_hold_done    = 1'b0;

    // Directed settings: section 0 runs on the values left by reset.
    // Section 1 has level three with its thresholds inverted, a zero flash
    // period for level two and a full-range one for level three.
    // Section 2 drops the warning at once on idle.
    cfg_t directed_cfg[3] = '{
        '0,
        '{knock_thresholds: 48'hA0C0_6040_2010, pulse_periods: 48'hFFFF_0000_0004,
          hold_time: 16'd3, load_floor: 16'h0100, throttle_floor: 16'h0100,
          drop_on_idle: 1'b0},
        '{knock_thresholds: 48'hA0C0_6040_2010, pulse_periods: 48'h0007_0003_0001,
          hold_time: 16'hFFFF, load_floor: 16'hFFFF, throttle_floor: 16'hFFFF,
          drop_on_idle: 1'b1}
    };

    script_row_t lamp_script[24] = '{
        // All thresholds zero: zero knock sets nothing, any knock sets all.
        '{0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, LEVEL_NONE},
        '{0, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1, LEVEL_THREE},
        '{0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0, LEVEL_NONE},
        // Level one rises, then the pulse timer decays.
        '{1, 16'h0030, 16'h0200, 16'h0200, 1'b0, 1'b0, 1'b0, 1'b0, LEVEL_NONE},
        '{1, 16'h0030, 16'h0200, 16'h0200, 1'b0, 1'b1, 1'b0, 1'b0, LEVEL_NONE},
        '{1, 16'h0030, 16'h0200, 16'h0200, 1'b0, 1'b1, 1'b0, 1'b0, LEVEL_NONE},
        // Level two with a zero period, then inverted level three thresholds.
        '{1, 16'h0070, 16'h0200, 16'h0200, 1'b0, 1'b0, 1'b0, 1'b0, LEVEL_NONE},
        '{1, 16'h0050, 16'h0200, 16'h0200, 1'b0, 1'b1, 1'b0, 1'b0, LEVEL_NONE},
        '{1, 16'h00B0, 16'h0200, 16'h0200, 1'b0, 1'b0, 1'b0, 1'b0, LEVEL_NONE},
        '{1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, LEVEL_NONE},
        // Idle load and throttle: the level lapses when the hold timer ends.
        '{1, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, LEVEL_NONE},
        '{1, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, LEVEL_NONE},
        '{1, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, LEVEL_NONE},
        '{1, 16'h0000, 16'h0200, 16'h0200, 1'b0, 1'b0, 1'b0, 1'b0, LEVEL_NONE},
        // Engine stopped: state is cleared before the flags are updated.
        '{1, 16'hFFFF, 16'h0200, 16'h0200, 1'b1, 1'b0, 1'b0, 1'b0, LEVEL_NONE},
        '{1, 16'h0000, 16'h0200, 16'h0200, 1'b1, 1'b1, 1'b0, 1'b0, LEVEL_NONE},
        '{1, 16'h0015, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, LEVEL_NONE},
        // Drop on idle only when both load and throttle are low.
        '{2, 16'h0025, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, LEVEL_NONE},
        '{2, 16'h0025, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, LEVEL_NONE},
        '{2, 16'h0025, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, LEVEL_NONE},
        '{2, 16'h0065, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0, LEVEL_NONE},
        '{2, 16'h0065, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0, LEVEL_NONE},
        '{2, 16'h00C5, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0, LEVEL_NONE},
        '{2, 16'h0015, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, LEVEL_NONE}
    };

    // Clock: 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hysteresis of one flag: the set test wins over the clear test.
    function automatic logic track_flag(input logic cur, input logic [15:0] knock,
                                        input logic [7:0] lo, input logic [7:0] hi);
        if (knock > hi)
            return 1'b1;
        if (knock < lo)
            return 1'b0;
        return cur;
    endfunction

    function automatic timer_t flash_period(input logic [1:0] lvl);
        case (lvl)
            LEVEL_ONE:   return timer_t'(lamp_cfg.pulse_periods[15:0]);
            LEVEL_TWO:   return timer_t'(lamp_cfg.pulse_periods[31:16]);
            LEVEL_THREE: return timer_t'(lamp_cfg.pulse_periods[47:32]);
            default:     return '0;
        endcase
    endfunction

    // Advances the shadow state by one tick and gives the lamp word it causes.
    task automatic predict_lamp(input tick_word_t w, output lamp_word_t r);
        logic [2:0] prev;
        logic [2:0] next;
        logic       rising;
        logic [1:0] lv;
        timer_t     per;
        if (w.decay_tick)
        begin
            if (hold_m != 0)
                hold_m = hold_m - 1'b1;
            if (pulse_m != 0)
                pulse_m = pulse_m - 1'b1;
        end
        prev = flags_m;
        if (w.not_running)
        begin
            flags_m = '0;
            level_m = LEVEL_NONE;
            hold_m  = '0;
            pulse_m = '0;
        end
        next = flags_m;
        next[FLAG_ONE]   = track_flag(next[FLAG_ONE], w.knock_level,
                                      lamp_cfg.knock_thresholds[7:0],
                                      lamp_cfg.knock_thresholds[15:8]);
        next[FLAG_TWO]   = track_flag(next[FLAG_TWO], w.knock_level,
                                      lamp_cfg.knock_thresholds[23:16],
                                      lamp_cfg.knock_thresholds[31:24]);
        next[FLAG_THREE] = track_flag(next[FLAG_THREE], w.knock_level,
                                      lamp_cfg.knock_thresholds[39:32],
                                      lamp_cfg.knock_thresholds[47:40]);
        flags_m = next;
        rising = |(next & ~prev);

        // Level update: idle drops or lets it lapse, otherwise relatch.
        if (w.engine_load < lamp_cfg.load_floor && w.throttle < lamp_cfg.throttle_floor)
        begin
            if (lamp_cfg.drop_on_idle)
            begin
                hold_m  = '0;
                level_m = LEVEL_NONE;
            end
            else if (hold_m == 0)
                level_m = LEVEL_NONE;
        end
        else if (hold_m == 0 || rising)
        begin
            if (next[FLAG_THREE])
                lv = LEVEL_THREE;
            else if (next[FLAG_TWO])
                lv = LEVEL_TWO;
            else if (next[FLAG_ONE])
                lv = LEVEL_ONE;
            else
                lv = LEVEL_NONE;
            level_m = lv;
            if (lv != LEVEL_NONE)
                hold_m = timer_t'(lamp_cfg.hold_time);
        end

        // Flashing: toggle while the pulse timer is in its upper half.
        r.toggle_lamp = 1'b0;
        if (level_m != LEVEL_NONE)
        begin
            per = flash_period(level_m);
            if (pulse_m == 0 || rising)
                pulse_m = per;
            r.toggle_lamp = (pulse_m >= per / 2);
        end
        else
            pulse_m = '0;
        r.warning_level = level_m;
    endtask

    // Offers one tick, with random gaps first, and books its lamp word.
    task automatic drive_tick(input tick_word_t w, input bit typed,
                              input lamp_word_t known);
        lamp_word_t predicted;
        bit         took;
        if (tx_burst_left > 0)
            tx_burst_left--;
        else if ($urandom_range(99) < 2)
            tx_burst_left = 24;
        else
        begin
            while ($urandom_range(99) < tx_idle_pct)
            begin
                tick_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        tick_ch.valid       <= 1'b1;
        tick_ch.knock_level <= w.knock_level;
        tick_ch.engine_load <= w.engine_load;
        tick_ch.throttle    <= w.throttle;
        tick_ch.not_running <= w.not_running;
        tick_ch.decay_tick  <= w.decay_tick;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = tick_ch.valid && tick_ch.ready;
            @(posedge clk);
        end
        predict_lamp(w, predicted);
        lamp_due_q.push_back(typed ? known : predicted);
    endtask

    // Stops offering and waits until every booked lamp word has come back.
    task automatic settle();
        tick_ch.valid <= 1'b0;
        while (lamp_due_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [47:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // Writes all six registers; junk fills the unused upper bits.
    task automatic write_settings(input cfg_t c, input bit junk);
        logic [31:0] fill;
        fill = junk ? $urandom : 32'd0;
        put_reg(CFG_KNOCK_THRESHOLDS, c.knock_thresholds);
        put_reg(CFG_PULSE_PERIODS, c.pulse_periods);
        put_reg(CFG_HOLD_TIME, {fill, c.hold_time});
        put_reg(CFG_LOAD_FLOOR, {fill, c.load_floor});
        put_reg(CFG_THROTTLE_FLOOR, {fill, c.throttle_floor});
        put_reg(CFG_DROP_ON_IDLE, {fill, fill[15:1], c.drop_on_idle});
        cfg_we <= 1'b0;
        lamp_cfg = c;
    endtask

    function automatic logic [15:0] short_or_wide(input int short_max);
        if ($urandom_range(99) < 80)
            return 16'($urandom_range(short_max));
        return 16'($urandom);
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.knock_thresholds = 48'({$urandom, $urandom});
        c.pulse_periods    = {short_or_wide(12), short_or_wide(12), short_or_wide(12)};
        c.hold_time        = short_or_wide(8);
        c.load_floor       = 16'($urandom);
        c.throttle_floor   = 16'($urandom);
        c.drop_on_idle     = 1'($urandom);
        return c;
    endfunction

    function automatic logic [15:0] near(input int centre, input int spread);
        int v;
        v = centre + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    // Most knock sums sit next to a threshold so that the flags move.
    function automatic tick_word_t random_tick(input cfg_t c);
        tick_word_t w;
        int         b;
        b = $urandom_range(5);
        if ($urandom_range(99) < 20)
            w.knock_level = 16'($urandom);
        else
            w.knock_level = near(int'(c.knock_thresholds[8 * b +: 8]), 3);
        w.engine_load = ($urandom_range(99) < 30) ? 16'($urandom)
                                                  : near(int'(c.load_floor), 2);
        w.throttle    = ($urandom_range(99) < 30) ? 16'($urandom)
                                                  : near(int'(c.throttle_floor), 2);
        w.not_running = ($urandom_range(99) < 3);
        w.decay_tick  = 1'($urandom);
        return w;
    endfunction

    // Lamp receiver: random stalls, bursts, and one long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            lamp_ch.ready <= 1'b0;
        else if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            lamp_ch.ready <= 1'b0;
        end
        else if (!rx_hold_done && lamp_words_seen >= LONG_STALL_AT)
        begin
            rx_hold_done = 1'b1;
            rx_hold_left = LONG_STALL_LEN;
            lamp_ch.ready <= 1'b0;
        end
        else if (rx_burst_left > 0)
        begin
            rx_burst_left--;
            lamp_ch.ready <= 1'b1;
        end
        else if ($urandom_range(99) < 2)
        begin
            rx_burst_left = 24;
            lamp_ch.ready <= 1'b1;
        end
        else
            lamp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare every taken lamp word with the oldest booked one.
    always @(negedge clk)
    begin : check_lamp
        lamp_word_t want;
        if (rst_n === 1'b1 && lamp_ch.valid === 1'b1 && lamp_ch.ready === 1'b1)
        begin
            lamp_words_seen++;
            if (lamp_due_q.size() == 0)
            begin
                $error("lamp word with none booked: toggle_lamp %0d, warning_level %0d",
                       lamp_ch.toggle_lamp, lamp_ch.warning_level);
                mismatch_count++;
            end
            else
            begin
                want = lamp_due_q.pop_front();
                if (lamp_ch.toggle_lamp !== want.toggle_lamp)
                begin
                    $error("toggle_lamp: expected %0d, actual %0d",
                           want.toggle_lamp, lamp_ch.toggle_lamp);
                    mismatch_count++;
                end
                if (lamp_ch.warning_level !== want.warning_level)
                begin
                    $error("warning_level: expected %0d, actual %0d",
                           want.warning_level, lamp_ch.warning_level);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        tick_word_t w;
        lamp_word_t known;
        cfg_t       c;
        int         section;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_KNOCK_THRESHOLDS;
        cfg_wdata           <= '0;
        tick_ch.valid       <= 1'b0;
        tick_ch.knock_level <= '0;
        tick_ch.engine_load <= '0;
        tick_ch.throttle    <= '0;
        tick_ch.not_running <= 1'b0;
        tick_ch.decay_tick  <= 1'b0;
        lamp_cfg        = '0;
        flags_m         = '0;
        level_m         = LEVEL_NONE;
        hold_m          = '0;
        pulse_m         = '0;
        tx_burst_left   = 0;
        tx_idle_pct     = 28;
        rx_idle_pct     = 52;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script.
        section = 0;
        foreach (lamp_script[i])
        begin
            if (lamp_script[i].section != section)
            begin
                section = lamp_script[i].section;
                settle();
                write_settings(directed_cfg[section], 1'b0);
            end
            w.knock_level       = lamp_script[i].knock_level;
            w.engine_load       = lamp_script[i].engine_load;
            w.throttle          = lamp_script[i].throttle;
            w.not_running       = lamp_script[i].not_running;
            w.decay_tick        = lamp_script[i].decay_tick;
            known.toggle_lamp   = lamp_script[i].toggle_lamp;
            known.warning_level = lamp_script[i].warning_level;
            drive_tick(w, lamp_script[i].typed, known);
        end

        // Random phases, each under its own settings; the extremes are
        // phase one (all ones) and phase three (all zeros).
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                1:       c = '1;
                3:       c = '0;
                default: c = random_settings();
            endcase
            write_settings(c, ph != 3);
            if (ph < 2)
            begin
                tx_idle_pct = 28;
                rx_idle_pct = 52;
            end
            else if (ph < 4)
            begin
                tx_idle_pct = 52;
                rx_idle_pct = 28;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                // Sender pause until the block has drained.
                if (ph == 2 && n == TICKS_PER_PHASE / 2)
                    settle();
                drive_tick(random_tick(c), 1'b0, '0);
            end
        end
        settle();
        repeat (5) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
